### rtl/fbfl_pkg.sv
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared constants, request/response types and state codes of the
// fixed block free list allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  localparam int MAX_BLOCKS   = 256;
  localparam int HEADER_BYTES = 12;
  localparam int ALIGN_BYTES  = 32;   // power of two
  localparam int ALIGN_SHIFT  = $clog2(ALIGN_BYTES);

  localparam int ADDR_W  = 32;
  localparam int BSIZE_W = 16;
  localparam int COUNT_W = 9;
  localparam int IDX_W   = $clog2(MAX_BLOCKS + 1);
  localparam int PTR_W   = $clog2(MAX_BLOCKS);
  localparam int RSZ_W   = BSIZE_W + 1;
  localparam int K_W     = RSZ_W - ALIGN_SHIFT;
  localparam int Q_W     = ADDR_W - ALIGN_SHIFT;
  localparam int PROD_W  = PTR_W + RSZ_W;
  localparam int QCNT_W  = $clog2(Q_W + 1);

  localparam logic [IDX_W-1:0] END_MARK = IDX_W'(MAX_BLOCKS);

  localparam logic [1:0] REG_BASE   = 2'd0;
  localparam logic [1:0] REG_BSIZE  = 2'd1;
  localparam logic [1:0] REG_BCOUNT = 2'd2;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_INIT,
    S_ALLOC,
    S_FREE,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t               opcode;
    logic [ADDR_W-1:0] block_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] granted_address;
    status_t           status;
  } rsp_t;

  typedef struct packed {
    logic           start;
    logic [Q_W-1:0] dividend;
    logic [K_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quotient;
    logic [K_W-1:0] remainder;
  } div_rsp_t;

endpackage

### rtl/fbfl_div.sv
// ----------------------------------------------------------------------------
// fbfl_div
// Restoring divider, one quotient bit per cycle: turns the aligned pool
// offset into a block index and remainder.
// ----------------------------------------------------------------------------
module fbfl_div (
  input  logic               clk,
  input  logic               rst,
  input  fbfl_pkg::div_req_t dreq,
  output fbfl_pkg::div_rsp_t drsp
);
  import fbfl_pkg::*;

  logic              busy;
  logic              done;
  logic [QCNT_W-1:0] cnt;
  logic [Q_W-1:0]    quo;
  logic [K_W-1:0]    rem;
  logic [K_W-1:0]    dsr;

  logic [K_W:0]      shifted;
  logic              ge;
  logic [K_W-1:0]    rem_next;

  always_comb begin
    shifted  = {rem, quo[Q_W-1]};
    ge       = shifted >= {1'b0, dsr};
    rem_next = ge ? K_W'(shifted - {1'b0, dsr}) : shifted[K_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !dreq.start && busy && (cnt == QCNT_W'(Q_W - 1));
      if (dreq.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == QCNT_W'(Q_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dreq.start) begin
      quo <= dreq.dividend;
      rem <= '0;
      dsr <= dreq.divisor;
    end else if (busy) begin
      quo <= {quo[Q_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign drsp.done      = done;
  assign drsp.quotient  = quo;
  assign drsp.remainder = rem;

endmodule

### rtl/fixed_block_free_list_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Pool of equal blocks kept on a LIFO free list; links live in a
// synchronous link memory, the head in a register.
//
//   channel   dir   handshake              payload
//   request   in    req_valid/req_ready    req_data  (opcode, block_address)
//   response  out   rsp_valid/rsp_ready    rsp_data  (granted_address, status)
//   config    in    psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// one request at a time; an init writes the links (one link write per cycle),
// an alloc reads the link memory, a free runs the divider (27 quotient bits,
// one per cycle in the divider); allocs on an empty list, zero-count inits,
// others and frees below the pool or off the alignment go straight to done.
// the next request is taken while a result waits in the output register;
// a second finished result holds the sequencer and drops req_ready.
// reset clears the head to the empty list; link memory needs no clearing.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  fbfl_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output fbfl_pkg::rsp_t rsp_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import fbfl_pkg::*;

  // configuration
  logic [ADDR_W-1:0]  base_address;
  logic [BSIZE_W-1:0] block_size;
  logic [COUNT_W-1:0] block_count;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      block_size   <= BSIZE_W'(ALIGN_BYTES);
      block_count  <= COUNT_W'(1);
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_BASE:   base_address <= pwdata;
        REG_BSIZE:  block_size   <= pwdata[BSIZE_W-1:0];
        REG_BCOUNT: block_count  <= pwdata[COUNT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BASE:   prdata = base_address;
      REG_BSIZE:  prdata = 32'(block_size);
      REG_BCOUNT: prdata = 32'(block_count);
      default:    prdata = '0;
    endcase
  end

  // derived pool geometry
  logic [RSZ_W-1:0]  bsize_nz;
  logic [K_W-1:0]    kval;
  logic [RSZ_W-1:0]  rsz;
  logic [IDX_W-1:0]  eff_n;
  logic [ADDR_W:0]   start_addr;
  logic [ADDR_W-1:0] offset;

  always_comb begin
    bsize_nz   = (block_size == '0) ? RSZ_W'(1) : RSZ_W'(block_size);
    kval       = K_W'((bsize_nz + RSZ_W'(ALIGN_BYTES - 1)) >> ALIGN_SHIFT);
    rsz        = RSZ_W'(kval) << ALIGN_SHIFT;
    eff_n      = (int'(block_count) > MAX_BLOCKS) ? END_MARK : IDX_W'(block_count);
    start_addr = {1'b0, base_address} + (ADDR_W + 1)'(HEADER_BYTES);
  end

  // state and work registers
  state_t            state, state_next;
  req_t              req_q;
  logic [IDX_W-1:0]  head;
  logic [PTR_W-1:0]  cnt;
  logic [PROD_W-1:0] prod;
  logic [ADDR_W-1:0] res_granted;
  status_t           res_status;

  assign offset = req_q.block_address - start_addr[ADDR_W-1:0];

  // link memory
  logic [IDX_W-1:0] link_mem [MAX_BLOCKS];
  logic [IDX_W-1:0] mem_rdata;
  logic             mem_re;
  logic [PTR_W-1:0] mem_raddr;
  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata <= link_mem[mem_raddr];
    end
  end

  // divider
  div_req_t dreq;
  div_rsp_t drsp;

  fbfl_div u_div (
    .clk  (clk),
    .rst  (rst),
    .dreq (dreq),
    .drsp (drsp)
  );

  logic             empty;
  logic             bad_pre;
  logic             free_ok;
  logic             init_last;
  logic [IDX_W-1:0] cnt_inc;
  logic             slot_free;

  always_comb begin
    empty     = head >= END_MARK;
    bad_pre   = ({1'b0, req_q.block_address} < start_addr) ||
                (offset[ALIGN_SHIFT-1:0] != '0);
    free_ok   = (drsp.remainder == '0) && (drsp.quotient < Q_W'(eff_n));
    cnt_inc   = IDX_W'(cnt) + 1'b1;
    init_last = cnt_inc == eff_n;
    slot_free = !rsp_valid || rsp_ready;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (req_q.opcode)
          OP_INIT:  state_next = (eff_n == '0) ? S_DONE : S_INIT;
          OP_ALLOC: state_next = empty ? S_DONE : S_ALLOC;
          OP_FREE:  state_next = bad_pre ? S_DONE : S_FREE;
          default:  state_next = S_DONE;
        endcase
      end
      S_INIT: begin
        if (init_last) state_next = S_DONE;
      end
      S_ALLOC: state_next = S_DONE;
      S_FREE: begin
        if (drsp.done) state_next = S_DONE;
      end
      S_DONE: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req_ready     = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = head[PTR_W-1:0];
    mem_we        = 1'b0;
    mem_waddr     = cnt;
    mem_wdata     = init_last ? END_MARK : cnt_inc;
    dreq.start    = 1'b0;
    dreq.dividend = offset[ADDR_W-1:ALIGN_SHIFT];
    dreq.divisor  = kval;
    case (state)
      S_IDLE: req_ready = 1'b1;
      S_EXEC: begin
        mem_re     = (req_q.opcode == OP_ALLOC) && !empty;
        dreq.start = (req_q.opcode == OP_FREE) && !bad_pre;
      end
      S_INIT: mem_we = 1'b1;
      S_FREE: begin
        if (drsp.done && free_ok) begin
          mem_we    = 1'b1;
          mem_waddr = drsp.quotient[PTR_W-1:0];
          mem_wdata = head;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= END_MARK;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_EXEC: begin
          cnt <= '0;
          if (req_q.opcode == OP_INIT && eff_n == '0) head <= END_MARK;
        end
        S_INIT: begin
          cnt <= cnt + 1'b1;
          if (init_last) head <= '0;
        end
        S_ALLOC: head <= mem_rdata;
        S_FREE: begin
          if (drsp.done && free_ok) head <= IDX_W'(drsp.quotient[PTR_W-1:0]);
        end
        default: ;
      endcase
      if (state == S_DONE && slot_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_valid) req_q <= req_data;
      end
      S_EXEC: begin
        res_granted <= '0;
        prod        <= PROD_W'(head[PTR_W-1:0]) * PROD_W'(rsz);
        if (req_q.opcode == OP_ALLOC && empty) begin
          res_status <= ST_EMPTY;
        end else if (req_q.opcode == OP_FREE && bad_pre) begin
          res_status <= ST_BADFREE;
        end else begin
          res_status <= ST_OK;
        end
      end
      S_ALLOC: res_granted <= start_addr[ADDR_W-1:0] + ADDR_W'(prod);
      S_FREE: begin
        if (drsp.done && !free_ok) res_status <= ST_BADFREE;
      end
      S_DONE: begin
        if (slot_free) begin
          rsp_data.granted_address <= res_granted;
          rsp_data.status          <= res_status;
        end
      end
      default: ;
    endcase
  end

  // checks
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    head <= END_MARK)
    else $error("head index beyond end mark");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> state == S_EXEC)
    else $error("accepted request not executed");

  a_alloc_read: assert property (@(posedge clk) disable iff (rst)
    state == S_ALLOC |-> $past(mem_re))
    else $error("alloc without link read");

  a_free_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_FREE && drsp.done) |=> state == S_DONE)
    else $error("free did not finish after divide");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_DONE)
    else $error("response raised outside done state");

endmodule

### dv/fixed_block_free_list_allocator_test.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_test
// Self-checking bench for the block free list allocator. A directed table
// covers reset state, init, alloc until empty, good and bad frees, double
// free, address wrap, zero size, zero and oversized counts and a stale head.
// Random phases follow, each with its own register setting. Most frees
// return blocks that were handed out earlier. Every request is predicted
// from a private copy of the pool registers and the free list. Results are
// compared in order, field by field.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_test;
  import fbfl_pkg::*;

  typedef struct packed {
    bit          cfg;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    op_t         op;
    logic [31:0] addr;
    bit          typed;
    logic [31:0] exp_addr;
    status_t     exp_st;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req_data = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0]      cfg_base  = 32'd0;
  logic [15:0]      cfg_bsize = 16'd32;
  logic [8:0]       cfg_count = 9'd1;
  logic [IDX_W-1:0] free_head = END_MARK;
  logic [IDX_W-1:0] free_next [MAX_BLOCKS];

  rsp_t        owed_results [$];
  logic [31:0] granted_blocks [$];
  step_row_t   directed_steps [$];
  int          mismatch_count = 0;
  bit          quiet = 1'b0;
  bit          long_hold = 1'b0;

  fixed_block_free_list_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic longint unsigned block_span();
    longint unsigned bs;
    bs = (cfg_bsize == 16'd0) ? 64'd1 : 64'(cfg_bsize);
    return ((bs + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  endfunction

  function automatic int pool_blocks();
    return (cfg_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(cfg_count);
  endfunction

  function automatic longint unsigned pool_start();
    return 64'(cfg_base) + HEADER_BYTES;
  endfunction

  function automatic rsp_t allocator_outcome(input req_t r);
    rsp_t            o;
    longint unsigned start;
    longint unsigned span;
    longint unsigned addr;
    int              n;
    int              i;
    int              idx;
    o.granted_address = '0;
    o.status = ST_OK;
    start = pool_start();
    span = block_span();
    addr = 64'(r.block_address);
    n = pool_blocks();
    case (r.opcode)
      OP_INIT: begin
        if (n == 0) begin
          free_head = END_MARK;
        end else begin
          for (i = 0; i + 1 < n; i++) free_next[i] = IDX_W'(i + 1);
          free_next[n-1] = END_MARK;
          free_head = '0;
        end
      end
      OP_ALLOC: begin
        if (free_head >= MAX_BLOCKS) begin
          o.status = ST_EMPTY;
        end else begin
          o.granted_address = 32'(start + 64'(free_head) * span);
          free_head = free_next[free_head[PTR_W-1:0]];
        end
      end
      OP_FREE: begin
        if (addr < start || ((addr - start) % span) != 0 ||
            ((addr - start) / span) >= 64'(n)) begin
          o.status = ST_BADFREE;
        end else begin
          idx = int'((addr - start) / span);
          free_next[idx] = free_head;
          free_head = IDX_W'(idx);
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic step_row_t cfg_step(input logic [1:0] idx, input logic [31:0] value);
    step_row_t s;
    s = '0;
    s.cfg = 1'b1;
    s.reg_idx = idx;
    s.value = value;
    return s;
  endfunction

  function automatic step_row_t req_step(input op_t op, input logic [31:0] addr,
                                         input bit typed, input logic [31:0] exp_addr,
                                         input status_t exp_st);
    step_row_t s;
    s = '0;
    s.op = op;
    s.addr = addr;
    s.typed = typed;
    s.exp_addr = exp_addr;
    s.exp_st = exp_st;
    return s;
  endfunction

  task automatic issue_request(input op_t op, input logic [31:0] addr,
                               input bit typed, input rsp_t want);
    req_t r;
    rsp_t outcome;
    int   gap;
    r.opcode = op;
    r.block_address = addr;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    outcome = allocator_outcome(r);
    owed_results.push_back(typed ? want : outcome);
    if (op == OP_INIT) granted_blocks.delete();
    if (op == OP_ALLOC && outcome.status == ST_OK)
      granted_blocks.push_back(outcome.granted_address);
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_BASE:   cfg_base = value;
      REG_BSIZE:  cfg_bsize = value[15:0];
      REG_BCOUNT: cfg_count = value[8:0];
      default: ;
    endcase
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int stall;
    forever begin
      if (long_hold) begin
        stall = 300;
        long_hold = 1'b0;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 3);
      end
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (owed_results.size() == 0) begin
        $display("%0t unexpected result: expected none, got granted_address %h status %0d",
                 $time, rsp_data.granted_address, rsp_data.status);
        mismatch_count++;
      end else begin
        want = owed_results.pop_front();
        if (rsp_data.granted_address !== want.granted_address) begin
          $display("%0t granted_address: expected %h, got %h",
                   $time, want.granted_address, rsp_data.granted_address);
          mismatch_count++;
        end
        if (rsp_data.status !== want.status) begin
          $display("%0t status: expected %0d, got %0d", $time, want.status, rsp_data.status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    step_row_t       s;
    rsp_t            want;
    logic [31:0]     addr;
    logic [31:0]     value;
    longint unsigned start;
    longint unsigned span;
    int              n;
    int              phase;
    int              k;
    int              j;
    int              pick;
    op_t             op;

    // reset values: pool of one 32 byte block at address 12
    directed_steps.push_back(req_step(OP_ALLOC, 32'h0, 1, 32'h0, ST_EMPTY));
    directed_steps.push_back(req_step(OP_FREE, 32'd12, 1, 32'h0, ST_OK));
    directed_steps.push_back(req_step(OP_ALLOC, 32'h0, 1, 32'd12, ST_OK));
    directed_steps.push_back(req_step(OP_ALLOC, 32'h0, 1, 32'h0, ST_EMPTY));
    directed_steps.push_back(req_step(OP_FREE, 32'd11, 1, 32'h0, ST_BADFREE));
    directed_steps.push_back(req_step(OP_FREE, 32'd13, 1, 32'h0, ST_BADFREE));
    directed_steps.push_back(req_step(OP_FREE, 32'd44, 1, 32'h0, ST_BADFREE));
    directed_steps.push_back(req_step(OP_NOP, 32'hFFFF_FFFF, 1, 32'h0, ST_OK));
    directed_steps.push_back(req_step(OP_INIT, 32'h0, 1, 32'h0, ST_OK));
    // double free loops block 0 onto itself
    directed_steps.push_back(req_step(OP_FREE, 32'd12, 1, 32'h0, ST_OK));
    directed_steps.push_back(req_step(OP_ALLOC, 32'h0, 1, 32'd12, ST_OK));
    directed_steps.push_back(req_step(OP_ALLOC, 32'h0, 1, 32'd12, ST_OK));
    // zero size, oversized count, pool wrapping past the top of memory
    directed_steps.push_back(cfg_step(REG_BASE, 32'hFFFF_FFF0));
    directed_steps.push_back(cfg_step(REG_BSIZE, 32'd0));
    directed_steps.push_back(cfg_step(REG_BCOUNT, 32'd511));
    directed_steps.push_back(req_step(OP_INIT, 32'h0, 1, 32'h0, ST_OK));
    directed_steps.push_back(req_step(OP_ALLOC, 32'h0, 1, 32'hFFFF_FFFC, ST_OK));
    directed_steps.push_back(req_step(OP_ALLOC, 32'h0, 1, 32'h0000_001C, ST_OK));
    directed_steps.push_back(req_step(OP_FREE, 32'hFFFF_FFFC, 1, 32'h0, ST_OK));
    directed_steps.push_back(req_step(OP_FREE, 32'h0000_001C, 1, 32'h0, ST_BADFREE));
    directed_steps.push_back(req_step(OP_FREE, 32'hFFFF_FFFF, 1, 32'h0, ST_BADFREE));
    directed_steps.push_back(req_step(OP_ALLOC, 32'h0, 1, 32'hFFFF_FFFC, ST_OK));
    directed_steps.push_back(req_step(OP_ALLOC, 32'h0, 0, 32'h0, ST_OK));
    // largest size, zero count, stale head
    directed_steps.push_back(cfg_step(REG_BSIZE, 32'd65535));
    directed_steps.push_back(cfg_step(REG_BASE, 32'h0));
    directed_steps.push_back(cfg_step(REG_BCOUNT, 32'd0));
    directed_steps.push_back(req_step(OP_ALLOC, 32'h0, 0, 32'h0, ST_OK));
    directed_steps.push_back(req_step(OP_INIT, 32'h0, 1, 32'h0, ST_OK));
    directed_steps.push_back(req_step(OP_ALLOC, 32'h0, 1, 32'h0, ST_EMPTY));
    directed_steps.push_back(req_step(OP_FREE, 32'd12, 1, 32'h0, ST_BADFREE));
    // full pool, last block and one past it
    directed_steps.push_back(cfg_step(REG_BASE, 32'h0000_1000));
    directed_steps.push_back(cfg_step(REG_BSIZE, 32'd33));
    directed_steps.push_back(cfg_step(REG_BCOUNT, 32'd256));
    directed_steps.push_back(req_step(OP_INIT, 32'h0, 1, 32'h0, ST_OK));
    directed_steps.push_back(req_step(OP_FREE, 32'h0000_4FCC, 0, 32'h0, ST_OK));
    directed_steps.push_back(req_step(OP_FREE, 32'h0000_500C, 1, 32'h0, ST_BADFREE));
    directed_steps.push_back(req_step(OP_ALLOC, 32'h0, 0, 32'h0, ST_OK));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      s = directed_steps[i];
      if (s.cfg) begin
        drain_results();
        program_reg(s.reg_idx, s.value);
      end else begin
        want.granted_address = s.exp_addr;
        want.status = s.exp_st;
        issue_request(s.op, s.addr, s.typed, want);
      end
    end

    want = '0;
    for (phase = 0; phase < 8; phase++) begin
      drain_results();
      quiet = (phase == 1) || ($urandom_range(0, 3) == 0);
      case (phase)
        0: begin
          program_reg(REG_BASE, 32'hFFFF_FFFF);
          program_reg(REG_BSIZE, 32'd65535);
          program_reg(REG_BCOUNT, 32'd256);
        end
        1: begin
          program_reg(REG_BASE, 32'h0);
          program_reg(REG_BSIZE, 32'd1);
          program_reg(REG_BCOUNT, 32'd1);
        end
        default: begin
          case ($urandom_range(0, 3))
            0: value = 32'h0;
            1: value = $urandom;
            2: value = $urandom_range(0, 4096);
            default: value = 32'hFFFF_FFFF - $urandom_range(0, 8192);
          endcase
          program_reg(REG_BASE, value);
          case ($urandom_range(0, 3))
            0: value = 32'd0;
            1: value = $urandom_range(1, 100);
            2: value = $urandom_range(1, 65535);
            default: value = $urandom_range(30, 70);
          endcase
          program_reg(REG_BSIZE, value);
          case ($urandom_range(0, 5))
            0: value = 32'd0;
            1: value = $urandom_range(257, 511);
            2: value = 32'd256;
            default: value = $urandom_range(1, 12);
          endcase
          program_reg(REG_BCOUNT, value);
        end
      endcase
      granted_blocks.delete();
      if (phase != 3) issue_request(OP_INIT, $urandom, 0, want);

      for (k = 0; k < 75; k++) begin
        if (phase == 2 && k == 10) long_hold = 1'b1;
        if (phase == 5 && k == 40) drain_results();
        start = pool_start();
        span = block_span();
        n = pool_blocks();
        pick = $urandom_range(0, 99);
        addr = $urandom;
        if (pick < 4) begin
          op = OP_INIT;
        end else if (pick < 48) begin
          op = OP_ALLOC;
        end else if (pick < 88) begin
          op = OP_FREE;
          if (granted_blocks.size() != 0 && $urandom_range(0, 3) != 0) begin
            j = $urandom_range(0, granted_blocks.size() - 1);
            addr = granted_blocks[j];
            granted_blocks.delete(j);
          end else if (n != 0) begin
            addr = 32'(start + 64'($urandom_range(0, n - 1)) * span);
          end
        end else if (pick < 96) begin
          op = OP_FREE;
          case ($urandom_range(0, 3))
            0: ;
            1: addr = 32'(start + 64'(n) * span);
            2: addr = 32'(start) - 32'd1;
            default: addr = 32'(start) + $urandom_range(1, 31);
          endcase
        end else begin
          op = OP_NOP;
        end
        issue_request(op, addr, 0, want);
      end
    end

    drain_results();
    repeat (300) @(posedge clk);
    if (owed_results.size() != 0) begin
      $display("%0t results still owed: expected 0, got %0d", $time, owed_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/fbfl_pkg.sv
rtl/fbfl_div.sv
rtl/fixed_block_free_list_allocator.sv
dv/fixed_block_free_list_allocator_test.sv
